// File: hdl/adrop_pkg.sv
// Package for the audio drop detector: widths, fixed-point constants,
// microcode control word types and the small arithmetic helper functions.
// No dependencies; every other file of the block refers to it by scoped names.
package adrop_pkg;

  // Internal fixed-point format: FRAC_BITS fraction bits, ONE = 2^FRAC_BITS.
  localparam int FRAC_BITS = 16;

  localparam int Q16_W  = 16;              // width of the Q0.16 port fields
  localparam int TIME_W = 16;              // elapsed time field
  localparam int LVL_W  = 7;               // percent fields
  localparam int LOCK_W = 19;              // lockout counter and register
  localparam int CFG_W  = 19;              // widest configuration register
  localparam int IDX_W  = 2;               // configuration register index
  localparam int PC_W   = 4;               // microcode step counter

  localparam int FX_W   = FRAC_BITS;       // converted input level
  localparam int S_W    = FRAC_BITS + 1;   // score, holds ONE itself
  localparam int ACC_W  = FRAC_BITS + 2;   // sum of the four terms
  localparam int Y_W    = FRAC_BITS + 7;   // score times sound level
  localparam int THR_W  = FRAC_BITS + 7;   // score times one hundred
  localparam int MUL_W  = FRAC_BITS + 8;   // multiplier operand
  localparam int PROD_W = 2 * MUL_W;       // multiplier product

  localparam logic [S_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FX_W-1:0] HALF_FX = {1'b1, {(FRAC_BITS - 1){1'b0}}};

  // Reciprocals for the constant divisions, rounded up. The shifts leave
  // enough headroom that floor(x * R >> SHIFT) is exact over the value range.
  localparam int DIV3_SHIFT  = ACC_W + 1;
  localparam int DIV50_SHIFT = Y_W + 6;
  localparam logic [63:0] RECIP3_64  = ((64'd1 << DIV3_SHIFT) / 64'd3) + 64'd1;
  localparam logic [63:0] RECIP50_64 = ((64'd1 << DIV50_SHIFT) / 64'd50) + 64'd1;
  localparam logic [MUL_W-1:0] RECIP3  = RECIP3_64[MUL_W-1:0];
  localparam logic [MUL_W-1:0] RECIP50 = RECIP50_64[MUL_W-1:0];

  localparam logic [LVL_W-1:0] SCORE_SCALE = 7'd100;
  localparam logic [LVL_W-1:0] SENS_MAX    = 7'd100;
  localparam logic [LVL_W-1:0] SENS_BASE   = 7'd110;
  localparam logic [LVL_W-1:0] LVL_LOW     = 7'd12;
  localparam logic [LVL_W-1:0] LVL_FULL    = 7'd50;
  localparam logic [LOCK_W-1:0] LOCK_MIN   = 19'd32768;
  localparam logic [LOCK_W-1:0] LOCK_MAX   = 19'd262144;
  localparam logic [LOCK_W-1:0] LOCK_RESET = 19'd122880;
  localparam logic [LVL_W-1:0] SENS_RESET  = 7'd50;

  // Microcode branch targets.
  localparam logic [PC_W-1:0] STEP_SCALE_MUL = 4'd11;
  localparam logic [PC_W-1:0] STEP_FINAL_MUL = 4'd14;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_DETECT_ENABLE = 2'd0,
    CFG_SENSITIVITY   = 2'd1,
    CFG_LOCKOUT       = 2'd2
  } cfg_index_t;

  // Multiplier operand selects.
  typedef enum logic [2:0] {
    MA_DSB  = 3'd0,
    MA_DFB  = 3'd1,
    MA_ACC  = 3'd2,
    MA_S    = 3'd3,
    MA_PROD = 3'd4
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_DSB   = 3'd0,
    MB_DFB   = 3'd1,
    MB_R3    = 3'd2,
    MB_LVL   = 3'd3,
    MB_R50   = 3'd4,
    MB_SCALE = 3'd5
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD       = 2'd0,
    ACC_LOAD_BASS  = 2'd1,
    ACC_ADD_TREBLE = 2'd2,
    ACC_ADD_WALK   = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    S_HOLD    = 2'd0,
    S_DIV3    = 2'd1,
    S_QUARTER = 2'd2,
    S_DIV50   = 2'd3
  } s_op_t;

  typedef enum logic [1:0] {
    BR_NEXT     = 2'd0,
    BR_ALWAYS   = 2'd1,
    BR_LVL_HIGH = 2'd2,
    BR_LVL_MID  = 2'd3
  } br_t;

  // One microcode control word.
  typedef struct packed {
    mul_a_t           mul_a;
    mul_b_t           mul_b;
    logic             mul_en;
    acc_op_t          acc_op;
    s_op_t            s_op;
    br_t              br;
    logic [PC_W-1:0]  target;
    logic             last;
  } ucode_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic lvl_high;   // sound level at fifty percent or more
    logic lvl_mid;    // sound level above twelve percent
    logic out_hold;   // result register full and not taken this cycle
  } adrop_stat_t;

  // Configuration register contents.
  typedef struct packed {
    logic              detect_enable;
    logic [LVL_W-1:0]  sensitivity_percent;
    logic [LOCK_W-1:0] lockout_ticks;
  } adrop_cfg_t;

  // One input word.
  typedef struct packed {
    logic [TIME_W-1:0] elapsed_time;
    logic [Q16_W-1:0]  slow_bass_level;
    logic [Q16_W-1:0]  slow_treble_level;
    logic [Q16_W-1:0]  slow_bass_walker;
    logic [Q16_W-1:0]  fast_bass_walker;
    logic [LVL_W-1:0]  sound_level_percent;
  } adrop_item_t;

  // Q0.16 to the internal format, rounded down.
  function automatic logic [FX_W-1:0] to_fx(input logic [Q16_W-1:0] q);
    logic [FRAC_BITS+Q16_W-1:0] t;
    t = {q, {FRAC_BITS{1'b0}}};
    return t[FRAC_BITS+Q16_W-1:Q16_W];
  endfunction

  // Rescaled level: (5x - ONE) / 4, zero below one fifth, at most ONE.
  function automatic logic [S_W-1:0] level_term(input logic [FX_W-1:0] x);
    logic [FX_W+2:0] five;
    logic [FX_W+2:0] one_ext;
    logic [FX_W+2:0] t;
    five    = {3'b000, x} + {1'b0, x, 2'b00};
    one_ext = {2'b00, ONE_FX};
    t       = (five - one_ext) >> 2;
    if (five <= one_ext) begin
      return '0;
    end else if (t > one_ext) begin
      return ONE_FX;
    end
    return t[S_W-1:0];
  endfunction

  // Distance of a walker position from one half.
  function automatic logic [FX_W-1:0] walker_dist(input logic [FX_W-1:0] w);
    return (w > HALF_FX) ? (w - HALF_FX) : (HALF_FX - w);
  endfunction

  // Clamp a quotient to ONE.
  function automatic logic [S_W-1:0] clamp_one(input logic [PROD_W-1:0] v);
    if (v > PROD_W'(ONE_FX)) begin
      return ONE_FX;
    end
    return v[S_W-1:0];
  endfunction

  // Internal format back to Q0.16, saturated.
  function automatic logic [Q16_W-1:0] to_q16(input logic [S_W-1:0] s);
    logic [S_W+Q16_W-1:0] t;
    logic [S_W+Q16_W-FRAC_BITS-1:0] q;
    t = {s, {Q16_W{1'b0}}};
    q = t[S_W+Q16_W-1:FRAC_BITS];
    if (q > {{(S_W - FRAC_BITS){1'b0}}, {Q16_W{1'b1}}}) begin
      return {Q16_W{1'b1}};
    end
    return q[Q16_W-1:0];
  endfunction

endpackage

// File: hdl/adrop_if.sv
// Valid/ready channel interfaces for the audio drop detector: the input
// word channel and the result word channel. Depends on adrop_pkg for widths.
interface adrop_in_if;
  logic                           valid;
  logic                           ready;
  logic [adrop_pkg::TIME_W-1:0]   elapsed_time;
  logic [adrop_pkg::Q16_W-1:0]    slow_bass_level;
  logic [adrop_pkg::Q16_W-1:0]    slow_treble_level;
  logic [adrop_pkg::Q16_W-1:0]    slow_bass_walker;
  logic [adrop_pkg::Q16_W-1:0]    fast_bass_walker;
  logic [adrop_pkg::LVL_W-1:0]    sound_level_percent;

  modport source (
    output valid, elapsed_time, slow_bass_level, slow_treble_level,
           slow_bass_walker, fast_bass_walker, sound_level_percent,
    input  ready
  );
  modport sink (
    input  valid, elapsed_time, slow_bass_level, slow_treble_level,
           slow_bass_walker, fast_bass_walker, sound_level_percent,
    output ready
  );
endinterface

interface adrop_out_if;
  logic                         valid;
  logic                         ready;
  logic                         drop_detected;
  logic [adrop_pkg::Q16_W-1:0]  drop_score;

  modport source (
    output valid, drop_detected, drop_score,
    input  ready
  );
  modport sink (
    input  valid, drop_detected, drop_score,
    output ready
  );
endinterface

// File: hdl/audio_drop_detector_core.sv
// Top level of the audio drop detector: channel handshakes, configuration
// registers and the microcoded engine (ROM, sequencer, datapath).
// Depends on adrop_pkg, adrop_if, adrop_ucode_rom, adrop_sequencer, adrop_datapath.

// Each input word runs through a 16-step microcode program on one shared
// 24x24 multiplier; the steps that it runs depend on whether the sound level
// is at fifty percent or more, twelve percent or less, or in between, and
// only one word is in work at a time. in_ch.ready is high whenever no word
// is in work; the result sits in an output register, and a new word is
// accepted while it waits. If a result has not been taken when the next word
// reaches its last step, that step waits. Configuration writes take effect at
// once and should be made
// while no word is in work.
module audio_drop_detector_core (
  input  logic                         clk,
  input  logic                         rst_n,
  adrop_in_if.sink                     in_ch,
  adrop_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [adrop_pkg::IDX_W-1:0]  cfg_index,
  input  logic [adrop_pkg::CFG_W-1:0]  cfg_wdata
);

  adrop_pkg::adrop_cfg_t       cfg_r, cfg_nxt;
  adrop_pkg::adrop_item_t      item;
  adrop_pkg::ucode_t           cw;
  adrop_pkg::adrop_stat_t      stat;
  logic [adrop_pkg::PC_W-1:0]  pc;
  logic                        busy;
  logic                        step_en;
  logic                        accept;

  // Input handshake: one word in work at a time.
  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  assign item.elapsed_time        = in_ch.elapsed_time;
  assign item.slow_bass_level     = in_ch.slow_bass_level;
  assign item.slow_treble_level   = in_ch.slow_treble_level;
  assign item.slow_bass_walker    = in_ch.slow_bass_walker;
  assign item.fast_bass_walker    = in_ch.fast_bass_walker;
  assign item.sound_level_percent = in_ch.sound_level_percent;

  // Configuration register writes; an unused index is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        adrop_pkg::CFG_DETECT_ENABLE: cfg_nxt.detect_enable = cfg_wdata[0];
        adrop_pkg::CFG_SENSITIVITY:
          cfg_nxt.sensitivity_percent = cfg_wdata[adrop_pkg::LVL_W-1:0];
        adrop_pkg::CFG_LOCKOUT:
          cfg_nxt.lockout_ticks = cfg_wdata[adrop_pkg::LOCK_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_enable       <= 1'b0;
      cfg_r.sensitivity_percent <= adrop_pkg::SENS_RESET;
      cfg_r.lockout_ticks       <= adrop_pkg::LOCK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adrop_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  adrop_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .cw      (cw),
    .stat    (stat),
    .pc      (pc),
    .busy    (busy),
    .step_en (step_en)
  );

  adrop_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .item         (item),
    .cfg          (cfg_r),
    .cw           (cw),
    .step_en      (step_en),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_detected (out_ch.drop_detected),
    .out_score    (out_ch.drop_score)
  );

endmodule

// File: hdl/adrop_ucode_rom.sv
// Control store of the drop detector: one control word per microcode step.
// Depends on adrop_pkg for the control word type and branch targets.
module adrop_ucode_rom (
  input  logic [adrop_pkg::PC_W-1:0] pc,
  output adrop_pkg::ucode_t          cw
);

  always_comb begin
    // Idle word; each step overrides what it uses.
    cw        = '0;
    cw.mul_a  = adrop_pkg::MA_DSB;
    cw.mul_b  = adrop_pkg::MB_DSB;
    cw.acc_op = adrop_pkg::ACC_HOLD;
    cw.s_op   = adrop_pkg::S_HOLD;
    cw.br     = adrop_pkg::BR_NEXT;
    unique case (pc)
      // Level terms of bass and treble.
      4'd0: begin
        cw.acc_op = adrop_pkg::ACC_LOAD_BASS;
      end
      4'd1: begin
        cw.acc_op = adrop_pkg::ACC_ADD_TREBLE;
      end
      // Walker terms: square the distance, then add twice it over ONE.
      4'd2: begin
        cw.mul_a  = adrop_pkg::MA_DSB;
        cw.mul_b  = adrop_pkg::MB_DSB;
        cw.mul_en = 1'b1;
      end
      4'd3: begin
        cw.acc_op = adrop_pkg::ACC_ADD_WALK;
      end
      4'd4: begin
        cw.mul_a  = adrop_pkg::MA_DFB;
        cw.mul_b  = adrop_pkg::MB_DFB;
        cw.mul_en = 1'b1;
      end
      4'd5: begin
        cw.acc_op = adrop_pkg::ACC_ADD_WALK;
      end
      // Divide the sum by three.
      4'd6: begin
        cw.mul_a  = adrop_pkg::MA_ACC;
        cw.mul_b  = adrop_pkg::MB_R3;
        cw.mul_en = 1'b1;
      end
      4'd7: begin
        cw.s_op = adrop_pkg::S_DIV3;
      end
      // Sound level scaling: loud keeps the score, quiet takes a quarter.
      4'd8: begin
        cw.br     = adrop_pkg::BR_LVL_HIGH;
        cw.target = adrop_pkg::STEP_FINAL_MUL;
      end
      4'd9: begin
        cw.br     = adrop_pkg::BR_LVL_MID;
        cw.target = adrop_pkg::STEP_SCALE_MUL;
      end
      4'd10: begin
        cw.s_op   = adrop_pkg::S_QUARTER;
        cw.br     = adrop_pkg::BR_ALWAYS;
        cw.target = adrop_pkg::STEP_FINAL_MUL;
      end
      // Otherwise score times level over fifty.
      4'd11: begin
        cw.mul_a  = adrop_pkg::MA_S;
        cw.mul_b  = adrop_pkg::MB_LVL;
        cw.mul_en = 1'b1;
      end
      4'd12: begin
        cw.mul_a  = adrop_pkg::MA_PROD;
        cw.mul_b  = adrop_pkg::MB_R50;
        cw.mul_en = 1'b1;
      end
      4'd13: begin
        cw.s_op = adrop_pkg::S_DIV50;
      end
      // Score times one hundred for the threshold compare.
      4'd14: begin
        cw.mul_a  = adrop_pkg::MA_S;
        cw.mul_b  = adrop_pkg::MB_SCALE;
        cw.mul_en = 1'b1;
      end
      // Decide, update the lockout and load the result register.
      4'd15: begin
        cw.last = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/adrop_sequencer.sv
// Microcode sequencer of the drop detector: step counter, busy flag and
// conditional jumps. Depends on adrop_pkg for the control word and flags.
module adrop_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  adrop_pkg::ucode_t          cw,
  input  adrop_pkg::adrop_stat_t     stat,
  output logic [adrop_pkg::PC_W-1:0] pc,
  output logic                       busy,
  output logic                       step_en
);

  logic [adrop_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                       busy_r, busy_nxt;
  logic                       take;

  // The final step waits while the previous result has not been taken.
  assign step_en = busy_r && !(cw.last && stat.out_hold);

  always_comb begin
    unique case (cw.br)
      adrop_pkg::BR_NEXT:     take = 1'b0;
      adrop_pkg::BR_ALWAYS:   take = 1'b1;
      adrop_pkg::BR_LVL_HIGH: take = stat.lvl_high;
      adrop_pkg::BR_LVL_MID:  take = stat.lvl_mid;
    endcase
  end

  // Next step and busy flag.
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (step_en) begin
      if (cw.last) begin
        pc_nxt   = '0;
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = busy_r;

endmodule

// File: hdl/adrop_datapath.sv
// Datapath of the drop detector: captured input word, shared multiplier,
// term accumulator, score, lockout counter and the result register.
// Driven by control words from adrop_ucode_rom; depends on adrop_pkg.
module adrop_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  adrop_pkg::adrop_item_t       item,
  input  adrop_pkg::adrop_cfg_t        cfg,
  input  adrop_pkg::ucode_t            cw,
  input  logic                         step_en,
  input  logic                         out_ready,
  output adrop_pkg::adrop_stat_t       stat,
  output logic                         out_valid,
  output logic                         out_detected,
  output logic [adrop_pkg::Q16_W-1:0]  out_score
);

  adrop_pkg::adrop_item_t              item_r;
  logic [adrop_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [adrop_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic [adrop_pkg::S_W-1:0]           s_r, s_nxt;
  logic [adrop_pkg::LOCK_W-1:0]        lock_r, lock_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_det_r, out_det_nxt;
  logic [adrop_pkg::Q16_W-1:0]         out_score_r, out_score_nxt;

  logic [adrop_pkg::FX_W-1:0]          d_sb, d_fb;
  logic [adrop_pkg::S_W-1:0]           lt_bass, lt_treble;
  logic [adrop_pkg::FRAC_BITS:0]       walk_term;
  logic [adrop_pkg::MUL_W-1:0]         mul_a, mul_b;
  logic [adrop_pkg::LVL_W-1:0]         sens_c;
  logic [adrop_pkg::THR_W-1:0]         thr;
  logic                                hit;
  logic [adrop_pkg::LOCK_W-1:0]        elapsed_ext;
  logic [adrop_pkg::LOCK_W-1:0]        reload;
  logic                                final_step;

  // Per-word terms from the captured fields.
  assign d_sb      = adrop_pkg::walker_dist(adrop_pkg::to_fx(item_r.slow_bass_walker));
  assign d_fb      = adrop_pkg::walker_dist(adrop_pkg::to_fx(item_r.fast_bass_walker));
  assign lt_bass   = adrop_pkg::level_term(adrop_pkg::to_fx(item_r.slow_bass_level));
  assign lt_treble = adrop_pkg::level_term(adrop_pkg::to_fx(item_r.slow_treble_level));
  // Twice the squared distance over ONE.
  assign walk_term = prod_r[2*adrop_pkg::FRAC_BITS-1:adrop_pkg::FRAC_BITS-1];

  // Flags for the sequencer.
  assign stat.lvl_high = item_r.sound_level_percent >= adrop_pkg::LVL_FULL;
  assign stat.lvl_mid  = item_r.sound_level_percent > adrop_pkg::LVL_LOW;
  assign stat.out_hold = out_valid_r && !out_ready;

  // Multiplier operand selection.
  always_comb begin
    unique case (cw.mul_a)
      adrop_pkg::MA_DSB:  mul_a = adrop_pkg::MUL_W'(d_sb);
      adrop_pkg::MA_DFB:  mul_a = adrop_pkg::MUL_W'(d_fb);
      adrop_pkg::MA_ACC:  mul_a = adrop_pkg::MUL_W'(acc_r);
      adrop_pkg::MA_S:    mul_a = adrop_pkg::MUL_W'(s_r);
      adrop_pkg::MA_PROD: mul_a = adrop_pkg::MUL_W'(prod_r[adrop_pkg::Y_W-1:0]);
      default:            mul_a = '0;
    endcase
    unique case (cw.mul_b)
      adrop_pkg::MB_DSB:   mul_b = adrop_pkg::MUL_W'(d_sb);
      adrop_pkg::MB_DFB:   mul_b = adrop_pkg::MUL_W'(d_fb);
      adrop_pkg::MB_R3:    mul_b = adrop_pkg::RECIP3;
      adrop_pkg::MB_LVL:   mul_b = adrop_pkg::MUL_W'(item_r.sound_level_percent);
      adrop_pkg::MB_R50:   mul_b = adrop_pkg::RECIP50;
      adrop_pkg::MB_SCALE: mul_b = adrop_pkg::MUL_W'(adrop_pkg::SCORE_SCALE);
      default:             mul_b = '0;
    endcase
  end

  // Multiplier, accumulator and score updates.
  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    s_nxt    = s_r;
    if (step_en) begin
      if (cw.mul_en) begin
        prod_nxt = mul_a * mul_b;
      end
      unique case (cw.acc_op)
        adrop_pkg::ACC_HOLD:       acc_nxt = acc_r;
        adrop_pkg::ACC_LOAD_BASS:  acc_nxt = adrop_pkg::ACC_W'(lt_bass);
        adrop_pkg::ACC_ADD_TREBLE: acc_nxt = acc_r + adrop_pkg::ACC_W'(lt_treble);
        adrop_pkg::ACC_ADD_WALK:   acc_nxt = acc_r + adrop_pkg::ACC_W'(walk_term);
      endcase
      unique case (cw.s_op)
        adrop_pkg::S_HOLD:    s_nxt = s_r;
        adrop_pkg::S_DIV3:    s_nxt = adrop_pkg::clamp_one(prod_r >> adrop_pkg::DIV3_SHIFT);
        adrop_pkg::S_QUARTER: s_nxt = s_r >> 2;
        adrop_pkg::S_DIV50:   s_nxt = adrop_pkg::clamp_one(prod_r >> adrop_pkg::DIV50_SHIFT);
      endcase
    end
  end

  // Threshold: score times one hundred against (110 - sensitivity) * ONE.
  assign sens_c = (cfg.sensitivity_percent > adrop_pkg::SENS_MAX) ?
                  adrop_pkg::SENS_MAX : cfg.sensitivity_percent;
  assign thr    = {adrop_pkg::SENS_BASE - sens_c, {adrop_pkg::FRAC_BITS{1'b0}}};
  assign hit    = prod_r[adrop_pkg::THR_W-1:0] > thr;

  assign elapsed_ext = adrop_pkg::LOCK_W'(item_r.elapsed_time);

  // Reload value kept within half a second to four seconds.
  always_comb begin
    priority if (cfg.lockout_ticks < adrop_pkg::LOCK_MIN) begin
      reload = adrop_pkg::LOCK_MIN;
    end else if (cfg.lockout_ticks > adrop_pkg::LOCK_MAX) begin
      reload = adrop_pkg::LOCK_MAX;
    end else begin
      reload = cfg.lockout_ticks;
    end
  end

  assign final_step = step_en && cw.last;

  // Lockout countdown or detection, and the result register.
  always_comb begin
    lock_nxt      = lock_r;
    out_det_nxt   = out_det_r;
    out_score_nxt = out_score_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (final_step) begin
      out_valid_nxt = 1'b1;
      out_score_nxt = adrop_pkg::to_q16(s_r);
      out_det_nxt   = 1'b0;
      if (lock_r != '0) begin
        lock_nxt = (lock_r > elapsed_ext) ? (lock_r - elapsed_ext) : '0;
      end else if (cfg.detect_enable && hit) begin
        lock_nxt    = reload;
        out_det_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    s_r         <= s_nxt;
    out_det_r   <= out_det_nxt;
    out_score_r <= out_score_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_detected = out_det_r;
  assign out_score    = out_score_r;

endmodule

// File: hdl/adrop_checker.sv
// Port-level checks for the audio drop detector, bound to the top level.
// Depends on adrop_pkg for widths and on audio_drop_detector_core.
module adrop_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_drop_detected,
  input logic [adrop_pkg::Q16_W-1:0]  out_drop_score
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_drop_score) && $stable(out_drop_detected))
    else $error("stalled result word changed");

  // Once a word is taken the engine is busy with it on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while a word is in work");

  // The threshold is never below one tenth, so a drop has a nonzero score.
  a_drop_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop_detected |-> out_drop_score != '0)
    else $error("drop flagged with zero score");

endmodule

bind audio_drop_detector_core adrop_checker u_adrop_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_drop_detected (out_ch.drop_detected),
  .out_drop_score    (out_ch.drop_score)
);

// File: tb/sv/testbench.sv
// Testbench for audio_drop_detector_core: directed and random input words under
// random stalls on both channels, every result checked against a local model.
// Depends on adrop_pkg, the channel interfaces in adrop_if and the block's RTL.
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 190;
  localparam int DRAIN_CYCLES  = 24;
  localparam int IDLE_PERCENT  = 13;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [adrop_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;

  // Model constants, in the internal fixed-point format where it applies.
  localparam logic [63:0] FX_ONE     = 64'd1 << adrop_pkg::FRAC_BITS;
  localparam logic [63:0] SENS_TOP   = 64'd100;
  localparam logic [63:0] THR_BASE   = 64'd110;
  localparam logic [63:0] PCT_SCALE  = 64'd100;
  localparam logic [63:0] QUIET_LVL  = 64'd12;
  localparam logic [63:0] FULL_LVL   = 64'd50;
  localparam logic [adrop_pkg::LOCK_W-1:0] RELOAD_MIN = 19'd32768;
  localparam logic [adrop_pkg::LOCK_W-1:0] RELOAD_MAX = 19'd262144;
  localparam logic [adrop_pkg::LOCK_W-1:0] LOCK_INIT  = 19'd122880;
  localparam logic [adrop_pkg::LVL_W-1:0]  SENS_INIT  = 7'd50;

  typedef struct packed {
    logic                        drop_detected;
    logic [adrop_pkg::Q16_W-1:0] drop_score;
  } drop_result_t;

  // Tracks the lockout and the registers, predicts one result word per tick
  // and compares the block's result words in order.
  class drop_checker;
    logic                         cfg_enable;
    logic [adrop_pkg::LVL_W-1:0]  cfg_sens;
    logic [adrop_pkg::LOCK_W-1:0] cfg_lock;
    logic [adrop_pkg::LOCK_W-1:0] lock_left;
    drop_result_t                 pending_results[$];
    int                           errors;

    function new();
      cfg_enable = 1'b0;
      cfg_sens   = SENS_INIT;
      cfg_lock   = LOCK_INIT;
      lock_left  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [adrop_pkg::IDX_W-1:0] idx,
                            logic [adrop_pkg::CFG_W-1:0] value);
      unique case (idx)
        adrop_pkg::CFG_DETECT_ENABLE: cfg_enable = value[0];
        adrop_pkg::CFG_SENSITIVITY:   cfg_sens   = value[adrop_pkg::LVL_W-1:0];
        adrop_pkg::CFG_LOCKOUT:       cfg_lock   = value[adrop_pkg::LOCK_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] fx_of(logic [adrop_pkg::Q16_W-1:0] q);
      return ({48'd0, q} << adrop_pkg::FRAC_BITS) >> 16;
    endfunction

    // Band level rescaled from one fifth..one to zero..one.
    function logic [63:0] band_part(logic [63:0] x);
      logic [63:0] five;
      logic [63:0] t;
      five = 64'd5 * x;
      if (five <= FX_ONE) return 64'd0;
      t = (five - FX_ONE) >> 2;
      return (t > FX_ONE) ? FX_ONE : t;
    endfunction

    // Twice the squared distance of a walker from one half.
    function logic [63:0] walker_part(logic [63:0] w);
      logic [63:0] half;
      logic [63:0] d;
      half = FX_ONE >> 1;
      d = (w > half) ? (w - half) : (half - w);
      return (64'd2 * d * d) >> adrop_pkg::FRAC_BITS;
    endfunction

    function void note_tick(adrop_pkg::adrop_item_t w);
      logic [63:0]                  s;
      logic [63:0]                  lvl;
      logic [63:0]                  sens;
      logic [63:0]                  q;
      logic [adrop_pkg::LOCK_W-1:0] reload;
      logic [adrop_pkg::LOCK_W-1:0] et;
      drop_result_t                 r;
      s = band_part(fx_of(w.slow_bass_level)) + band_part(fx_of(w.slow_treble_level))
        + walker_part(fx_of(w.slow_bass_walker)) + walker_part(fx_of(w.fast_bass_walker));
      s = s / 64'd3;
      if (s > FX_ONE) s = FX_ONE;

      // Sound level scaling: a quarter when quiet, full weight from fifty up.
      lvl = 64'(w.sound_level_percent);
      if (lvl <= QUIET_LVL) begin
        s = s >> 2;
      end else if (lvl < FULL_LVL) begin
        s = (s * lvl) / FULL_LVL;
      end
      if (s > FX_ONE) s = FX_ONE;

      // A running lockout only counts down; otherwise test the threshold.
      et = adrop_pkg::LOCK_W'(w.elapsed_time);
      r.drop_detected = 1'b0;
      if (lock_left != '0) begin
        if (lock_left > et) begin
          lock_left = lock_left - et;
        end else begin
          lock_left = '0;
        end
      end else if (cfg_enable) begin
        sens = (64'(cfg_sens) > SENS_TOP) ? SENS_TOP : 64'(cfg_sens);
        if (s * PCT_SCALE > (THR_BASE - sens) * FX_ONE) begin
          reload = cfg_lock;
          if (reload < RELOAD_MIN) reload = RELOAD_MIN;
          if (reload > RELOAD_MAX) reload = RELOAD_MAX;
          lock_left = reload;
          r.drop_detected = 1'b1;
        end
      end

      q = (s << 16) >> adrop_pkg::FRAC_BITS;
      r.drop_score = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      pending_results.push_back(r);
    endfunction

    function void check_tick_result(drop_result_t got);
      drop_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: drop_detected %0d, drop_score %0d",
               got.drop_detected, got.drop_score);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.drop_detected !== want.drop_detected) begin
        $error("drop_detected: expected %0d, actual %0d", want.drop_detected,
               got.drop_detected);
        errors++;
      end
      if (got.drop_score !== want.drop_score) begin
        $error("drop_score: expected %0d, actual %0d", want.drop_score, got.drop_score);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [adrop_pkg::IDX_W-1:0] cfg_index;
  logic [adrop_pkg::CFG_W-1:0] cfg_wdata;
  bit                          steady;
  int                          cycles;
  drop_checker                 chk = new();

  adrop_in_if  in_ch();
  adrop_out_if out_ch();

  audio_drop_detector_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Each accepted input word goes to the model.
  always @(posedge clk) begin : in_monitor
    adrop_pkg::adrop_item_t w;
    w.elapsed_time        = in_ch.elapsed_time;
    w.slow_bass_level     = in_ch.slow_bass_level;
    w.slow_treble_level   = in_ch.slow_treble_level;
    w.slow_bass_walker    = in_ch.slow_bass_walker;
    w.fast_bass_walker    = in_ch.fast_bass_walker;
    w.sound_level_percent = in_ch.sound_level_percent;
    if (rst_n && in_ch.valid && in_ch.ready) chk.note_tick(w);
  end

  // Each accepted result word is checked.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chk.check_tick_result(drop_result_t'{out_ch.drop_detected, out_ch.drop_score});
    end
  end

  // The result side stalls at random unless in a steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  function automatic adrop_pkg::adrop_item_t mk_word(logic [15:0] et, logic [15:0] bass,
                                                     logic [15:0] treble, logic [15:0] sw,
                                                     logic [15:0] fw, logic [6:0] snd);
    adrop_pkg::adrop_item_t w;
    w.elapsed_time        = et;
    w.slow_bass_level     = bass;
    w.slow_treble_level   = treble;
    w.slow_bass_walker    = sw;
    w.fast_bass_walker    = fw;
    w.sound_level_percent = snd;
    return w;
  endfunction

  // Loud ticks with high levels and far walkers, plain random ticks and quiet ones.
  function automatic adrop_pkg::adrop_item_t random_word();
    adrop_pkg::adrop_item_t w;
    int unsigned mode;
    mode = $urandom_range(9);
    w.elapsed_time = ($urandom_range(1) == 0) ? 16'($urandom_range(4095)) : 16'($urandom);
    if (mode < 4) begin
      w.slow_bass_level     = 16'($urandom);
      w.slow_treble_level   = 16'($urandom);
      w.slow_bass_walker    = 16'($urandom);
      w.fast_bass_walker    = 16'($urandom);
      w.sound_level_percent = 7'($urandom_range(127));
    end else if (mode < 8) begin
      w.slow_bass_level     = 16'($urandom_range(65535, 45000));
      w.slow_treble_level   = 16'($urandom_range(65535, 45000));
      w.slow_bass_walker    = ($urandom_range(1) == 0) ? 16'($urandom_range(8000))
                                                      : 16'($urandom_range(65535, 57000));
      w.fast_bass_walker    = ($urandom_range(1) == 0) ? 16'($urandom_range(8000))
                                                      : 16'($urandom_range(65535, 57000));
      w.sound_level_percent = 7'($urandom_range(127, 30));
    end else begin
      w.slow_bass_level     = 16'($urandom_range(20000));
      w.slow_treble_level   = 16'($urandom_range(20000));
      w.slow_bass_walker    = 16'($urandom_range(40000, 25000));
      w.fast_bass_walker    = 16'($urandom_range(40000, 25000));
      w.sound_level_percent = 7'($urandom_range(60));
    end
    return w;
  endfunction

  // Offer one word, with random idle cycles ahead of it, until accepted.
  task automatic send_word(input adrop_pkg::adrop_item_t w);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.elapsed_time        <= w.elapsed_time;
    in_ch.slow_bass_level     <= w.slow_bass_level;
    in_ch.slow_treble_level   <= w.slow_treble_level;
    in_ch.slow_bass_walker    <= w.slow_bass_walker;
    in_ch.fast_bass_walker    <= w.fast_bass_walker;
    in_ch.sound_level_percent <= w.sound_level_percent;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering words and let every outstanding result come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (chk.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [adrop_pkg::IDX_W-1:0] idx,
                         input logic [adrop_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    chk.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic program_config(input logic en, input logic [adrop_pkg::LVL_W-1:0] sens,
                                input logic [adrop_pkg::LOCK_W-1:0] lock);
    wait_drained();
    put_reg(adrop_pkg::CFG_DETECT_ENABLE, adrop_pkg::CFG_W'(en));
    put_reg(adrop_pkg::CFG_SENSITIVITY, adrop_pkg::CFG_W'(sens));
    put_reg(adrop_pkg::CFG_LOCKOUT, adrop_pkg::CFG_W'(lock));
    put_reg(CFG_SPARE, adrop_pkg::CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_wdata                 = '0;
    steady                    = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.elapsed_time        = '0;
    in_ch.slow_bass_level     = '0;
    in_ch.slow_treble_level   = '0;
    in_ch.slow_bass_walker    = '0;
    in_ch.fast_bass_walker    = '0;
    in_ch.sound_level_percent = '0;
    out_ch.ready              = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, detection off: field extremes and level boundaries.
    send_word(mk_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0));
    send_word(mk_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127));
    send_word(mk_word(16'd100, 16'd13107, 16'd13108, 16'h8000, 16'h8000, 7'd50));
    send_word(mk_word(16'd100, 16'd13108, 16'd13107, 16'h7FFF, 16'h8001, 7'd12));
    send_word(mk_word(16'd100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd13));
    send_word(mk_word(16'd100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd49));
    send_word(mk_word(16'd100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'd100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd101));

    // Detection on, lockout register below range: detect, count down, expire.
    program_config(1'b1, 7'd100, 19'd0);
    send_word(mk_word(16'd1000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'd1000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'd1000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd100));
    send_word(mk_word(16'hFFFF, 16'h4000, 16'h4000, 16'h8000, 16'h8000, 7'd20));

    // Sensitivity above one hundred, lockout register above range.
    program_config(1'b1, 7'd127, 19'h7FFFF);
    send_word(mk_word(16'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 7'd60));
    repeat (4) begin
      send_word(mk_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 7'd60));
    end
    send_word(mk_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 7'd60));
    send_word(mk_word(16'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 7'd60));

    // Random phases, each under its own register settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      unique case (p)
        0: program_config(1'b1, 7'd100, 19'd32768);
        1: program_config(1'b1, 7'd0, 19'd262144);
        2: program_config(1'b1, 7'd127, 19'd0);
        3: program_config(1'b1, 7'd50, 19'h7FFFF);
        4: program_config(1'b0, 7'($urandom_range(127)), 19'($urandom));
        default: program_config($urandom_range(3) != 0, 7'($urandom_range(127)),
                                19'($urandom));
      endcase
      steady = (p == 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_word());
      end
    end
    steady = 1'b0;

    wait_drained();
    if (chk.errors == 0 && chk.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
